/* src/assert_macros.svh */
// Assertion macros for the effective address unit RTL.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Clocked check, disabled while reset is asserted
`define EAU_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("eau assertion failed");
// Clocked check that also runs during reset
`define EAU_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("eau assertion failed");
`else
`define EAU_ASSERT(label, clk, rst_n, prop)
`define EAU_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

/* src/eau_pkg.sv */
// Package for the effective address unit: item types, codes, phases and
// small helper functions. No dependencies.
`default_nettype none

package eau_pkg;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned WORD_W  = 16;
    localparam int unsigned REG_CNT = 16;
    localparam int unsigned REG_AW  = $clog2(REG_CNT);

    // Item modes
    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_START = 2'd1;
    localparam logic [1:0] MODE_WORD  = 2'd2;
    localparam logic [1:0] MODE_DATA  = 2'd3;

    // Result kinds
    localparam logic [1:0] KIND_NEED    = 2'd0;
    localparam logic [1:0] KIND_READ    = 2'd1;
    localparam logic [1:0] KIND_READY   = 2'd2;
    localparam logic [1:0] KIND_INVALID = 2'd3;

    // EA mode field
    localparam logic [2:0] EA_AN_IND  = 3'd2;
    localparam logic [2:0] EA_POSTINC = 3'd3;
    localparam logic [2:0] EA_PREDEC  = 3'd4;
    localparam logic [2:0] EA_DISP    = 3'd5;
    localparam logic [2:0] EA_INDEX   = 3'd6;
    localparam logic [2:0] EA_EXTRA   = 3'd7;

    // EA register field under mode 7
    localparam logic [2:0] XR_ABS_W    = 3'd0;
    localparam logic [2:0] XR_ABS_L    = 3'd1;
    localparam logic [2:0] XR_PC_DISP  = 3'd2;
    localparam logic [2:0] XR_PC_INDEX = 3'd3;

    localparam logic [2:0] A7_REG = 3'd7;

    // Operand sizes
    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_WORD = 2'd1;

    // Extension word fields
    localparam int unsigned EXT_FULL_BIT     = 8;
    localparam int unsigned EXT_IDX_LONG_BIT = 11;
    localparam int unsigned EXT_BS_BIT       = 7;
    localparam int unsigned EXT_IS_BIT       = 6;
    localparam int unsigned EXT_POST_BIT     = 2;

    // Base displacement size codes
    localparam logic [1:0] BD_WORD = 2'd2;
    localparam logic [1:0] BD_LONG = 2'd3;

    // Indirect / outer displacement selection codes
    localparam logic [1:0] IIS_NONE    = 2'd0;
    localparam logic [1:0] IIS_OD_NULL = 2'd1;
    localparam logic [1:0] IIS_OD_WORD = 2'd2;
    localparam logic [1:0] IIS_OD_LONG = 2'd3;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_DISP,
        PH_ABSW,
        PH_ABSL_HI,
        PH_ABSL_LO,
        PH_EXT,
        PH_BD_W,
        PH_BD_HI,
        PH_BD_LO,
        PH_OD_W,
        PH_OD_HI,
        PH_OD_LO,
        PH_WAIT
    } t_phase;

    typedef struct packed {
        logic [1:0]        mode;
        logic [REG_AW-1:0] load_index;
        logic [31:0]       load_value;
        logic [2:0]        ea_mode;
        logic [2:0]        ea_reg;
        logic [1:0]        size_code;
        logic [31:0]       pc_value;
        logic [15:0]       ext_word;
        logic [31:0]       indirect_data;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [31:0] address;
        logic        writeback_valid;
        logic [2:0]  writeback_reg;
        logic [31:0] writeback_value;
    } t_out_item;

    // Register copy write request
    typedef struct packed {
        logic              en;
        logic [REG_AW-1:0] addr;
        logic [DATA_W-1:0] data;
    } t_reg_wr;

    function automatic logic [31:0] sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] sx8(input logic [7:0] v);
        return {{24{v[7]}}, v};
    endfunction

    // Index register, optionally sign extended from a word, suppressed, scaled
    function automatic logic [31:0] scaled_index(input logic [15:0] ext,
                                                 input logic [31:0] val,
                                                 input logic        full);
        logic [31:0] r;
        r = ext[EXT_IDX_LONG_BIT] ? val : sx16(val[15:0]);
        if (full && ext[EXT_IS_BIT]) begin
            r = '0;
        end
        return r << ext[10:9];
    endfunction

endpackage

`default_nettype wire

/* src/eau_chan_if.sv */
// Valid/ready channel interface carrying one item of type T.
// No dependencies; the item type is given at instantiation.
`default_nettype none

interface eau_chan_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* src/eau_regfile.sv */
// Register copy of D0-D7/A0-A7: one write port, one registered read port
// with write-first bypass and reset-cleared valid flags. Uses eau_pkg.
`default_nettype none

module eau_regfile (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire eau_pkg::t_reg_wr              i_wr,
    input  wire logic                          i_rd_en,
    input  wire logic [eau_pkg::REG_AW-1:0]    i_raddr,
    output logic      [eau_pkg::DATA_W-1:0]    o_rdata
);
    import eau_pkg::*;

    logic [DATA_W-1:0]  mem [REG_CNT];
    logic [REG_CNT-1:0] r_vld;
    logic [DATA_W-1:0]  r_rdata;

    // Storage write
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.data;
        end
    end

    // Entries read as zero until written after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr.en) begin
            r_vld[i_wr.addr] <= 1'b1;
        end
    end

    // Registered read, a same-cycle write wins
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr.en && (i_wr.addr == i_raddr)) begin
                r_rdata <= i_wr.data;
            end else if (r_vld[i_raddr]) begin
                r_rdata <= mem[i_raddr];
            end else begin
                r_rdata <= '0;
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* src/effective_address_unit.sv */
// Effective address unit top level: request sequencing, address arithmetic,
// result register. Uses eau_pkg, eau_chan_if, eau_regfile, assert_macros.svh.
//
// Usage:
//   i_in carries register loads, address requests, extension words and
//   indirect read data; o_out carries at most one result per item (need word,
//   indirect read request, address ready or invalid mode, with any An
//   write-back). Both are valid/ready channels; an item moves when valid and
//   ready are both high at a rising edge.
//   An accepted item is held in the input register; its result is loaded into
//   the output register when that one is empty or being taken, and is offered
//   on o_out from then on. One item per cycle is sustained while the receiver
//   takes results; the figure is set by the single calculation stage between
//   input and result register, whose register operand comes from the copy's
//   one registered read port. Loads and items with no result pass this stage.
//   Reset (synchronous, active low) empties both registers, returns the
//   request sequencer to idle and makes all sixteen register copies read as
//   zero at once; no clearing pass follows.
//   When the receiver stalls, the result waits in the output register and
//   the next item waits in the input register; i_in.ready drops only when
//   both are full and o_out is not taken.
`include "assert_macros.svh"
`default_nettype none

module effective_address_unit (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    eau_chan_if.sink   i_in,
    eau_chan_if.source o_out
);
    import eau_pkg::*;

    // Pipeline registers
    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;

    // Request state
    t_phase      r_phase, n_phase;
    logic [15:0] r_ext, n_ext;
    logic [31:0] r_bd, n_bd;
    logic [31:0] r_od, n_od;
    logic [15:0] r_hi, n_hi;
    logic [31:0] r_base, n_base;

    logic              accept;
    logic              advance;
    logic              has_res;
    t_out_item         res;
    t_reg_wr           wr;
    logic [REG_AW-1:0] raddr;
    logic [DATA_W-1:0] rd_data;

    logic [15:0] e_cur;
    logic [31:0] idx_full;
    logic [31:0] base_full;
    logic [31:0] bd_cur;
    logic [31:0] step;
    logic [31:0] an_new;
    logic        do_bd;
    logic        do_od;

    // Handshake
    assign advance     = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || advance;
    assign accept      = i_in.valid && i_in.ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // Register copy
    eau_regfile u_regfile (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (wr),
        .i_rd_en (accept),
        .i_raddr (raddr),
        .o_rdata (rd_data)
    );

    // Read address for the incoming item, from the state it will see
    always_comb begin
        unique case (i_in.data.mode)
            MODE_START: raddr = {1'b1, i_in.data.ea_reg};
            MODE_WORD:  raddr = (n_phase == PH_EXT) ? i_in.data.ext_word[15:12]
                                                    : n_ext[15:12];
            default:    raddr = n_ext[15:12];
        endcase
    end

    // Step size for (An)+ and -(An)
    always_comb begin
        case (r_in.size_code)
            SIZE_BYTE: step = (r_in.ea_reg == A7_REG) ? 32'd2 : 32'd1;
            SIZE_WORD: step = 32'd2;
            default:   step = 32'd4;
        endcase
    end

    // Calculation stage
    always_comb begin
        n_phase = r_phase;
        n_ext   = r_ext;
        n_bd    = r_bd;
        n_od    = r_od;
        n_hi    = r_hi;
        n_base  = r_base;
        res     = '0;
        has_res = 1'b0;
        wr      = '0;
        do_bd   = 1'b0;
        do_od   = 1'b0;
        bd_cur  = r_bd;
        an_new  = '0;

        e_cur     = ((r_in.mode == MODE_WORD) && (r_phase == PH_EXT)) ? r_in.ext_word
                                                                      : r_ext;
        idx_full  = scaled_index(e_cur, rd_data, 1'b1);
        base_full = e_cur[EXT_BS_BIT] ? '0 : r_base;

        if (advance) begin
            unique case (r_in.mode)
                MODE_LOAD: begin
                    wr.en   = 1'b1;
                    wr.addr = r_in.load_index;
                    wr.data = r_in.load_value;
                end
                MODE_START: begin
                    has_res = 1'b1;
                    n_bd    = '0;
                    n_od    = '0;
                    n_hi    = '0;
                    n_ext   = '0;
                    n_phase = PH_IDLE;
                    res.result_kind = KIND_NEED;
                    case (r_in.ea_mode)
                        EA_AN_IND: begin
                            res.result_kind = KIND_READY;
                            res.address     = rd_data;
                        end
                        EA_POSTINC: begin
                            an_new = rd_data + step;
                            res.result_kind     = KIND_READY;
                            res.address         = rd_data;
                            res.writeback_valid = 1'b1;
                            res.writeback_reg   = r_in.ea_reg;
                            res.writeback_value = an_new;
                            wr = '{en: 1'b1, addr: {1'b1, r_in.ea_reg}, data: an_new};
                        end
                        EA_PREDEC: begin
                            an_new = rd_data - step;
                            res.result_kind     = KIND_READY;
                            res.address         = an_new;
                            res.writeback_valid = 1'b1;
                            res.writeback_reg   = r_in.ea_reg;
                            res.writeback_value = an_new;
                            wr = '{en: 1'b1, addr: {1'b1, r_in.ea_reg}, data: an_new};
                        end
                        EA_DISP: begin
                            n_base  = rd_data;
                            n_phase = PH_DISP;
                        end
                        EA_INDEX: begin
                            n_base  = rd_data;
                            n_phase = PH_EXT;
                        end
                        EA_EXTRA: begin
                            n_base = r_in.pc_value;
                            case (r_in.ea_reg)
                                XR_ABS_W:    n_phase = PH_ABSW;
                                XR_ABS_L:    n_phase = PH_ABSL_HI;
                                XR_PC_DISP:  n_phase = PH_DISP;
                                XR_PC_INDEX: n_phase = PH_EXT;
                                default:     res.result_kind = KIND_INVALID;
                            endcase
                        end
                        default: res.result_kind = KIND_INVALID;
                    endcase
                end
                MODE_WORD: begin
                    unique case (r_phase)
                        PH_DISP: begin
                            has_res = 1'b1;
                            n_phase = PH_IDLE;
                            res.result_kind = KIND_READY;
                            res.address     = r_base + sx16(r_in.ext_word);
                        end
                        PH_ABSW: begin
                            has_res = 1'b1;
                            n_phase = PH_IDLE;
                            res.result_kind = KIND_READY;
                            res.address     = sx16(r_in.ext_word);
                        end
                        PH_ABSL_HI: begin
                            has_res = 1'b1;
                            n_hi    = r_in.ext_word;
                            n_phase = PH_ABSL_LO;
                            res.result_kind = KIND_NEED;
                        end
                        PH_ABSL_LO: begin
                            has_res = 1'b1;
                            n_phase = PH_IDLE;
                            res.result_kind = KIND_READY;
                            res.address     = {r_hi, r_in.ext_word};
                        end
                        PH_EXT: begin
                            has_res = 1'b1;
                            n_ext   = r_in.ext_word;
                            if (!r_in.ext_word[EXT_FULL_BIT]) begin
                                // brief format
                                n_phase = PH_IDLE;
                                res.result_kind = KIND_READY;
                                res.address = r_base
                                    + scaled_index(r_in.ext_word, rd_data, 1'b0)
                                    + sx8(r_in.ext_word[7:0]);
                            end else begin
                                n_bd = '0;
                                case (r_in.ext_word[5:4])
                                    BD_WORD: begin
                                        n_phase = PH_BD_W;
                                        res.result_kind = KIND_NEED;
                                    end
                                    BD_LONG: begin
                                        n_phase = PH_BD_HI;
                                        res.result_kind = KIND_NEED;
                                    end
                                    default: begin
                                        bd_cur = '0;
                                        do_bd  = 1'b1;
                                    end
                                endcase
                            end
                        end
                        PH_BD_W: begin
                            has_res = 1'b1;
                            bd_cur  = sx16(r_in.ext_word);
                            do_bd   = 1'b1;
                        end
                        PH_BD_HI: begin
                            has_res = 1'b1;
                            n_hi    = r_in.ext_word;
                            n_phase = PH_BD_LO;
                            res.result_kind = KIND_NEED;
                        end
                        PH_BD_LO: begin
                            has_res = 1'b1;
                            bd_cur  = {r_hi, r_in.ext_word};
                            do_bd   = 1'b1;
                        end
                        PH_OD_W: begin
                            has_res = 1'b1;
                            n_od    = sx16(r_in.ext_word);
                            do_od   = 1'b1;
                        end
                        PH_OD_HI: begin
                            has_res = 1'b1;
                            n_hi    = r_in.ext_word;
                            n_phase = PH_OD_LO;
                            res.result_kind = KIND_NEED;
                        end
                        PH_OD_LO: begin
                            has_res = 1'b1;
                            n_od    = {r_hi, r_in.ext_word};
                            do_od   = 1'b1;
                        end
                        default: ;  // word not awaited
                    endcase
                end
                default: begin
                    // indirect longword arrives
                    if (r_phase == PH_WAIT) begin
                        has_res = 1'b1;
                        n_phase = PH_IDLE;
                        res.result_kind = KIND_READY;
                        res.address = r_in.indirect_data + r_od
                            + (r_ext[EXT_POST_BIT] ? idx_full : 32'd0);
                    end
                end
            endcase

            // Base displacement complete: choose indirection
            if (do_bd) begin
                n_bd = bd_cur;
                case (e_cur[1:0])
                    IIS_NONE: begin
                        n_phase = PH_IDLE;
                        res.result_kind = KIND_READY;
                        res.address     = base_full + idx_full + bd_cur;
                    end
                    IIS_OD_NULL: begin
                        n_od  = '0;
                        do_od = 1'b1;
                    end
                    IIS_OD_WORD: begin
                        n_phase = PH_OD_W;
                        res.result_kind = KIND_NEED;
                    end
                    default: begin
                        n_phase = PH_OD_HI;
                        res.result_kind = KIND_NEED;
                    end
                endcase
            end

            // Outer displacement known: request the indirect longword
            if (do_od) begin
                n_phase = PH_WAIT;
                res.result_kind = KIND_READ;
                res.address = base_full + bd_cur
                    + (e_cur[EXT_POST_BIT] ? 32'd0 : idx_full);
            end
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_in.data;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && has_res) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && has_res) begin
            r_out <= res;
        end
    end

    // Request state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_ext   <= '0;
            r_bd    <= '0;
            r_od    <= '0;
            r_hi    <= '0;
            r_base  <= '0;
        end else begin
            r_phase <= n_phase;
            r_ext   <= n_ext;
            r_bd    <= n_bd;
            r_od    <= n_od;
            r_hi    <= n_hi;
            r_base  <= n_base;
        end
    end

    // Checks
    `EAU_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !r_out_valid && !r_in_valid && r_phase == PH_IDLE)
    `EAU_ASSERT(a_read_waits, i_clk, i_rst_n, advance && has_res && res.result_kind == KIND_READ |=> r_phase == PH_WAIT)
    `EAU_ASSERT(a_wb_ready, i_clk, i_rst_n, r_out_valid && r_out.writeback_valid |-> r_out.result_kind == KIND_READY)
    `EAU_ASSERT(a_need_zero, i_clk, i_rst_n, r_out_valid && (r_out.result_kind == KIND_NEED || r_out.result_kind == KIND_INVALID) |-> r_out.address == 32'd0 && !r_out.writeback_valid)
    `EAU_ASSERT(a_in_hold, i_clk, i_rst_n, r_in_valid && !advance |=> r_in_valid)

endmodule

`default_nettype wire

/* sim/tb_top.sv */
// Testbench for effective_address_unit: random and directed address requests,
// checked item by item against a behavioral predictor of the unit.
// Depends on eau_pkg, eau_chan_if and the effective_address_unit RTL.
`default_nettype none

module tb_top;
    import eau_pkg::*;

    // Mode and size codes that the package leaves unnamed
    localparam logic [2:0] EA_DATA_DIRECT = 3'd0;
    localparam logic [2:0] EA_ADDR_DIRECT = 3'd1;
    localparam logic [2:0] XR_IMMEDIATE   = 3'd4;
    localparam logic [2:0] XR_RESERVED    = 3'd7;
    localparam logic [1:0] SIZE_LONG      = 2'd2;
    localparam logic [1:0] SIZE_RESERVED  = 2'd3;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned RANDOM_ITEMS = 1250;
    localparam int unsigned MAX_REPORTS  = 100;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    eau_chan_if #(.T(t_in_item))  in_ch ();
    eau_chan_if #(.T(t_out_item)) out_ch ();

    effective_address_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Predictor state: mirror of the unit's registers and request sequencer
    logic [31:0] reg_mirror [16];
    t_phase      seq_phase;
    logic [15:0] ext_word_q;
    logic [31:0] base_disp;
    logic [31:0] outer_disp;
    logic [15:0] upper_word;
    logic [31:0] req_base;

    t_out_item   expected_ea_q [$];

    int unsigned err_count   = 0;
    int unsigned items_sent  = 0;   // loads plus items that produce a result
    int unsigned cycle_cnt   = 0;
    int unsigned rx_hold_len = 0;
    bit          idle_on     = 1'b1;

    // Clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("effective_address_unit test failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------
    function automatic logic [31:0] sext16(input logic [15:0] v);
        logic signed [15:0] s;
        logic signed [31:0] t;
        s = v;
        t = s;
        return t;
    endfunction

    function automatic logic [31:0] sext8(input logic [7:0] v);
        logic signed [7:0]  s;
        logic signed [31:0] t;
        s = v;
        t = s;
        return t;
    endfunction

    function automatic t_out_item mk_res(input logic [1:0] kind, input logic [31:0] addr,
                                         input logic wb_v, input logic [2:0] wb_r,
                                         input logic [31:0] wb_val);
        t_out_item r;
        r.result_kind     = kind;
        r.address         = addr;
        r.writeback_valid = wb_v;
        r.writeback_reg   = wb_r;
        r.writeback_value = wb_val;
        return r;
    endfunction

    // Index register term: word or long, suppressed in full format, scaled
    function automatic logic [31:0] idx_term(input bit full);
        logic [31:0] r;
        r = reg_mirror[ext_word_q[15:12]];
        if (!ext_word_q[EXT_IDX_LONG_BIT])
            r = sext16(r[15:0]);
        if (full && ext_word_q[EXT_IS_BIT])
            r = '0;
        return r << ext_word_q[10:9];
    endfunction

    function automatic logic [31:0] base_term();
        return ext_word_q[EXT_BS_BIT] ? 32'd0 : req_base;
    endfunction

    // Outer displacement known: issue the indirect read
    function automatic t_out_item after_outer();
        logic [31:0] a;
        a = base_term() + base_disp;
        if (!ext_word_q[EXT_POST_BIT])
            a = a + idx_term(1'b1);
        seq_phase = PH_WAIT;
        return mk_res(KIND_READ, a, 1'b0, 3'd0, 32'd0);
    endfunction

    // Base displacement known: finish, or go on to the memory indirect part
    function automatic t_out_item after_base();
        case (ext_word_q[1:0])
            IIS_NONE: begin
                seq_phase = PH_IDLE;
                return mk_res(KIND_READY, base_term() + idx_term(1'b1) + base_disp,
                              1'b0, 3'd0, 32'd0);
            end
            IIS_OD_NULL: begin
                outer_disp = '0;
                return after_outer();
            end
            IIS_OD_WORD: begin
                seq_phase = PH_OD_W;
                return mk_res(KIND_NEED, 32'd0, 1'b0, 3'd0, 32'd0);
            end
            default: begin
                seq_phase = PH_OD_HI;
                return mk_res(KIND_NEED, 32'd0, 1'b0, 3'd0, 32'd0);
            end
        endcase
    endfunction

    function automatic t_out_item ea_start(input t_in_item it);
        logic [2:0]  em;
        logic [2:0]  er;
        logic [3:0]  an_i;
        logic [31:0] step;
        logic [31:0] a;
        t_out_item   need;
        em   = it.ea_mode;
        er   = it.ea_reg;
        an_i = {1'b1, er};
        step = (it.size_code >= SIZE_LONG) ? 32'd4 : (32'd1 << it.size_code);
        // byte access on A7 keeps the stack word aligned
        if (er == A7_REG && step == 32'd1)
            step = 32'd2;
        need       = mk_res(KIND_NEED, 32'd0, 1'b0, 3'd0, 32'd0);
        base_disp  = '0;
        outer_disp = '0;
        upper_word = '0;
        ext_word_q = '0;
        seq_phase  = PH_IDLE;
        case (em)
            EA_AN_IND:
                return mk_res(KIND_READY, reg_mirror[an_i], 1'b0, 3'd0, 32'd0);
            EA_POSTINC: begin
                a = reg_mirror[an_i];
                reg_mirror[an_i] = a + step;
                return mk_res(KIND_READY, a, 1'b1, er, reg_mirror[an_i]);
            end
            EA_PREDEC: begin
                reg_mirror[an_i] = reg_mirror[an_i] - step;
                return mk_res(KIND_READY, reg_mirror[an_i], 1'b1, er, reg_mirror[an_i]);
            end
            EA_DISP: begin
                req_base  = reg_mirror[an_i];
                seq_phase = PH_DISP;
                return need;
            end
            EA_INDEX: begin
                req_base  = reg_mirror[an_i];
                seq_phase = PH_EXT;
                return need;
            end
            EA_EXTRA: begin
                req_base = it.pc_value;
                case (er)
                    XR_ABS_W:    seq_phase = PH_ABSW;
                    XR_ABS_L:    seq_phase = PH_ABSL_HI;
                    XR_PC_DISP:  seq_phase = PH_DISP;
                    XR_PC_INDEX: seq_phase = PH_EXT;
                    default:
                        return mk_res(KIND_INVALID, 32'd0, 1'b0, 3'd0, 32'd0);
                endcase
                return need;
            end
            default:
                return mk_res(KIND_INVALID, 32'd0, 1'b0, 3'd0, 32'd0);
        endcase
    endfunction

    // Extension word; returns 0 when no word is awaited
    function automatic bit ea_word(input logic [15:0] w, output t_out_item res);
        t_out_item need;
        need = mk_res(KIND_NEED, 32'd0, 1'b0, 3'd0, 32'd0);
        res  = need;
        case (seq_phase)
            PH_DISP: begin
                seq_phase = PH_IDLE;
                res = mk_res(KIND_READY, req_base + sext16(w), 1'b0, 3'd0, 32'd0);
            end
            PH_ABSW: begin
                seq_phase = PH_IDLE;
                res = mk_res(KIND_READY, sext16(w), 1'b0, 3'd0, 32'd0);
            end
            PH_ABSL_HI: begin
                upper_word = w;
                seq_phase  = PH_ABSL_LO;
            end
            PH_ABSL_LO: begin
                seq_phase = PH_IDLE;
                res = mk_res(KIND_READY, {upper_word, w}, 1'b0, 3'd0, 32'd0);
            end
            PH_EXT: begin
                ext_word_q = w;
                if (!w[EXT_FULL_BIT]) begin
                    // brief format
                    seq_phase = PH_IDLE;
                    res = mk_res(KIND_READY, req_base + idx_term(1'b0) + sext8(w[7:0]),
                                 1'b0, 3'd0, 32'd0);
                end else begin
                    base_disp = '0;
                    case (w[5:4])
                        BD_WORD: seq_phase = PH_BD_W;
                        BD_LONG: seq_phase = PH_BD_HI;
                        default: res = after_base();   // null or reserved size
                    endcase
                end
            end
            PH_BD_W: begin
                base_disp = sext16(w);
                res = after_base();
            end
            PH_BD_HI: begin
                upper_word = w;
                seq_phase  = PH_BD_LO;
            end
            PH_BD_LO: begin
                base_disp = {upper_word, w};
                res = after_base();
            end
            PH_OD_W: begin
                outer_disp = sext16(w);
                res = after_outer();
            end
            PH_OD_HI: begin
                upper_word = w;
                seq_phase  = PH_OD_LO;
            end
            PH_OD_LO: begin
                outer_disp = {upper_word, w};
                res = after_outer();
            end
            default: return 1'b0;
        endcase
        return 1'b1;
    endfunction

    // One accepted item; returns 1 and the expected result if it causes one
    function automatic bit predict_ea(input t_in_item it, output t_out_item res);
        logic [31:0] a;
        res = '0;
        case (it.mode)
            MODE_LOAD: begin
                reg_mirror[it.load_index] = it.load_value;
                return 1'b0;
            end
            MODE_START: begin
                res = ea_start(it);
                return 1'b1;
            end
            MODE_WORD:
                return ea_word(it.ext_word, res);
            default: begin
                // indirect data only counts while the read is outstanding
                if (seq_phase != PH_WAIT)
                    return 1'b0;
                seq_phase = PH_IDLE;
                a = it.indirect_data + outer_disp;
                if (ext_word_q[EXT_POST_BIT])
                    a = a + idx_term(1'b1);
                res = mk_res(KIND_READY, a, 1'b0, 3'd0, 32'd0);
                return 1'b1;
            end
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    function automatic t_in_item rand_item();
        t_in_item    it;
        logic [31:0] r;
        r = $urandom;
        it.mode          = r[1:0];
        it.load_index    = r[5:2];
        it.ea_mode       = r[8:6];
        it.ea_reg        = r[11:9];
        it.size_code     = r[13:12];
        it.ext_word      = r[31:16];
        it.load_value    = $urandom;
        it.pc_value      = $urandom;
        it.indirect_data = $urandom;
        return it;
    endfunction

    function automatic logic [15:0] pick_word();
        logic [31:0] r;
        r = $urandom;
        case (r[18:16])
            3'd0:    return 16'h0000;
            3'd1:    return 16'hFFFF;
            3'd2:    return 16'h8000;
            3'd3:    return 16'h7FFF;
            default: return r[15:0];
        endcase
    endfunction

    function automatic logic [31:0] pick_long();
        logic [31:0] r;
        r = $urandom;
        case (r[2:0])
            3'd0:    return 32'h0000_0000;
            3'd1:    return 32'hFFFF_FFFF;
            3'd2:    return 32'h8000_0000;
            3'd3:    return 32'h7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (err_count < MAX_REPORTS)
            $display("MISMATCH %s: got %h, expected %h", what, got, want);
        err_count++;
    endtask

    // Offer one item, wait for it to be taken, then predict its result
    task automatic send_item(input t_in_item it);
        int unsigned gap;
        bit          has_res;
        t_out_item   res;
        gap = idle_on ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        do @(posedge i_clk); while (!in_ch.ready);
        has_res = predict_ea(it, res);
        if (has_res)
            expected_ea_q.push_back(res);
        if (has_res || it.mode == MODE_LOAD)
            items_sent++;
    endtask

    task automatic send_load(input logic [3:0] idx, input logic [31:0] val);
        t_in_item it;
        it = rand_item();
        it.mode       = MODE_LOAD;
        it.load_index = idx;
        it.load_value = val;
        send_item(it);
    endtask

    task automatic send_start(input logic [2:0] em, input logic [2:0] er,
                              input logic [1:0] sz, input logic [31:0] pc);
        t_in_item it;
        it = rand_item();
        it.mode      = MODE_START;
        it.ea_mode   = em;
        it.ea_reg    = er;
        it.size_code = sz;
        it.pc_value  = pc;
        send_item(it);
    endtask

    task automatic send_word(input logic [15:0] w);
        t_in_item it;
        it = rand_item();
        it.mode     = MODE_WORD;
        it.ext_word = w;
        send_item(it);
    endtask

    task automatic send_data(input logic [31:0] d);
        t_in_item it;
        it = rand_item();
        it.mode          = MODE_DATA;
        it.indirect_data = d;
        send_item(it);
    endtask

    // One address request fed with the words it asks for; now and then a
    // register load, a stray item or an early abandon gets in the way
    task automatic run_request();
        logic [31:0] r;
        logic [2:0]  em;
        logic [2:0]  er;
        logic [15:0] w;
        r  = $urandom;
        em = r[6:4];
        er = r[9:7];
        case (r[3:0])
            4'd0: ;   // any mode field, invalid ones included
            4'd1: em = EA_AN_IND;
            4'd2: em = EA_POSTINC;
            4'd3: em = EA_PREDEC;
            4'd4: em = EA_DISP;
            4'd5, 4'd6, 4'd7, 4'd8: em = EA_INDEX;
            4'd9: begin
                em = EA_EXTRA;
                er = XR_ABS_W;
            end
            4'd10: begin
                em = EA_EXTRA;
                er = XR_ABS_L;
            end
            4'd11: begin
                em = EA_EXTRA;
                er = XR_PC_DISP;
            end
            default: begin
                em = EA_EXTRA;
                er = XR_PC_INDEX;
            end
        endcase
        send_start(em, er, r[11:10], pick_long());
        while (seq_phase != PH_IDLE) begin
            r = $urandom;
            if (r[5:0] == 6'd0)
                break;
            if (r[9:6] == 4'd0) begin
                send_load(r[13:10], pick_long());
            end else if (r[19:14] == 6'd0) begin
                send_item(rand_item());
            end else if (seq_phase == PH_WAIT) begin
                send_data(pick_long());
            end else if (seq_phase == PH_EXT) begin
                w = pick_word();
                w[EXT_FULL_BIT] = (r[21:20] != 2'd0);
                send_word(w);
            end else begin
                send_word(pick_word());
            end
        end
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    task automatic test_directed();
        send_load(4'd0, 32'hFFFF_FFFF);                       // D0 all ones
        send_start(EA_DATA_DIRECT, 3'd0, SIZE_LONG, 32'd0);   // register direct
        send_start(EA_ADDR_DIRECT, 3'd5, SIZE_WORD, 32'd0);
        send_start(EA_EXTRA, XR_IMMEDIATE, SIZE_WORD, 32'd0); // mode 7, reg 4..7
        send_start(EA_EXTRA, XR_RESERVED, SIZE_LONG, 32'd0);
        send_start(EA_POSTINC, A7_REG, SIZE_BYTE, 32'd0);     // A7 byte steps by 2
        send_start(EA_PREDEC, 3'd0, SIZE_RESERVED, 32'd0);    // size 3 acts as long
        send_start(EA_AN_IND, A7_REG, SIZE_WORD, 32'd0);
        send_start(EA_DISP, 3'd0, SIZE_WORD, 32'd0);
        send_word(16'h8000);
        send_start(EA_EXTRA, XR_ABS_W, SIZE_WORD, 32'd0);
        send_word(16'hFFFF);
        send_start(EA_EXTRA, XR_ABS_L, SIZE_LONG, 32'd0);
        send_word(16'hFFFF);
        send_word(16'h0001);
        send_start(EA_EXTRA, XR_PC_DISP, SIZE_WORD, 32'hFFFF_FFFE);
        send_word(16'h7FFF);
        // brief format: D0 as word index, scale 8, d8 = -128
        send_start(EA_INDEX, 3'd7, SIZE_WORD, 32'd0);
        send_word(16'h0680);
        // full format on PC: long D0 index, scale 4, long bd and od, postindexed
        send_start(EA_EXTRA, XR_PC_INDEX, SIZE_LONG, 32'hFFFF_FFF0);
        send_word(16'h0D37);
        send_word(16'hFFFF);
        send_word(16'h0000);
        send_word(16'h7FFF);
        send_word(16'hFFFF);
        send_data(32'hFFFF_FFFF);
        // nothing awaited: both are dropped
        send_word(16'h1234);
        send_data(32'h5555_AAAA);
        // a new request abandons the one in progress
        send_start(EA_DISP, 3'd1, SIZE_WORD, 32'd0);
        send_start(EA_AN_IND, 3'd1, SIZE_WORD, 32'd0);
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering
    task automatic test_backpressure();
        int unsigned stop_at;
        stop_at     = items_sent + 60;
        idle_on     = 1'b0;
        rx_hold_len = 300;
        while (items_sent < stop_at)
            run_request();
        idle_on = 1'b1;
    endtask

    // Sender stops until every outstanding result has come back
    task automatic test_sender_pause();
        int unsigned k;
        for (k = 0; k < 4; k++) begin
            run_request();
            run_request();
            in_ch.valid <= 1'b0;
            do @(posedge i_clk); while (expected_ea_q.size() != 0);
        end
    endtask

    task automatic test_random();
        int unsigned stop_at;
        int unsigned done_cnt;
        logic [31:0] r;
        stop_at = items_sent + RANDOM_ITEMS;
        while (items_sent < stop_at) begin
            done_cnt = RANDOM_ITEMS - (stop_at - items_sent);
            // a stretch with no idling on either side
            idle_on = !(done_cnt >= 400 && done_cnt < 550);
            r = $urandom;
            if (r[3:0] < 4'd12)
                run_request();
            else if (r[3:0] < 4'd14)
                send_load(r[7:4], pick_long());
            else
                send_item(rand_item());
        end
        idle_on = 1'b1;
    endtask

    // ---------------------------------------------------------------
    // Result side: receiver stalls and result checks
    // ---------------------------------------------------------------
    initial begin : rx_side
        int unsigned w;
        out_ch.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (rx_hold_len > 0) begin
                out_ch.ready <= 1'b0;
                repeat (rx_hold_len) @(posedge i_clk);
                rx_hold_len = 0;
            end
            w = idle_on ? $urandom_range(0, 10) : 0;
            if (w > 0) begin
                out_ch.ready <= 1'b0;
                repeat (w) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(out_ch.valid && out_ch.ready));
        end
    end

    always @(posedge i_clk) begin : result_check
        t_out_item got;
        t_out_item want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = out_ch.data;
            if (expected_ea_q.size() == 0) begin
                report_mismatch("result with nothing expected", got.address, 32'd0);
            end else begin
                want = expected_ea_q.pop_front();
                if (got.result_kind !== want.result_kind)
                    report_mismatch("result_kind", got.result_kind, want.result_kind);
                if (got.address !== want.address)
                    report_mismatch("address", got.address, want.address);
                if (got.writeback_valid !== want.writeback_valid)
                    report_mismatch("writeback_valid", got.writeback_valid,
                                    want.writeback_valid);
                if (got.writeback_reg !== want.writeback_reg)
                    report_mismatch("writeback_reg", got.writeback_reg, want.writeback_reg);
                if (got.writeback_value !== want.writeback_value)
                    report_mismatch("writeback_value", got.writeback_value,
                                    want.writeback_value);
            end
        end
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin
        in_ch.valid <= 1'b0;
        in_ch.data  <= '0;
        foreach (reg_mirror[i])
            reg_mirror[i] = '0;
        seq_phase  = PH_IDLE;
        ext_word_q = '0;
        base_disp  = '0;
        outer_disp = '0;
        upper_word = '0;
        req_base   = '0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_backpressure();
        test_sender_pause();
        test_random();

        // drain, then allow for items still in flight that cause no result
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (expected_ea_q.size() != 0);
        repeat (8) @(posedge i_clk);

        if (err_count == 0) begin
            $display("effective_address_unit test passed");
        end else begin
            $display("effective_address_unit test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* sim.f */
+incdir+src
src/eau_pkg.sv
src/eau_chan_if.sv
src/eau_regfile.sv
src/effective_address_unit.sv
sim/tb_top.sv
